/* design/band_level_meter_tracker_defines.svh */
// Assertion helpers for the band level meter tracker.
`ifndef BAND_LEVEL_METER_TRACKER_DEFINES_SVH
`define BAND_LEVEL_METER_TRACKER_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define BLMT_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define BLMT_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/blmt_pkg.sv */
`timescale 1ns / 1ps
package blmt_pkg;

  // Field widths of the request and result channels
  localparam int BAND_W   = 3;
  localparam int MAG_IN_W = 32;
  localparam int COLOR_W  = 8;

  // Internal fixed-point widths: 32.16 state, Q1.16 levels
  localparam int MAG_W    = 48;
  localparam int LEVEL_W  = 17;
  localparam int COEF_W   = 16;
  localparam int QUOT_W   = 16;
  localparam int ACC_W    = 64;
  localparam int MUL_A_W  = 32;
  localparam int PROD_W   = MUL_A_W + LEVEL_W;

  // Configuration port
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_FLOOR_RISE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FLOOR_FALL  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PEAK_ATTACK = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PEAK_DECAY  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SMOOTH      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ON_THRESH   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_OFF_RATIO   = 3'd6;

  // Register reset values
  localparam logic [COEF_W-1:0]  RST_FLOOR_RISE  = 16'd64880;
  localparam logic [COEF_W-1:0]  RST_FLOOR_FALL  = 16'd62259;
  localparam logic [COEF_W-1:0]  RST_PEAK_ATTACK = 16'd32768;
  localparam logic [COEF_W-1:0]  RST_PEAK_DECAY  = 16'd65208;
  localparam logic [COEF_W-1:0]  RST_SMOOTH      = 16'd19661;
  localparam logic [LEVEL_W-1:0] RST_ON_THRESH   = 17'd6554;
  localparam logic [COEF_W-1:0]  RST_OFF_RATIO   = 16'd45875;

  // Fixed-point constants
  localparam logic [LEVEL_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [LEVEL_W-1:0] HALF_Q16  = 17'd32768;
  localparam logic [LEVEL_W-1:0] RAMP_SPAN = 17'd300;
  localparam logic [COLOR_W-1:0] RED_MAX   = 8'd150;

endpackage

/* design/blmt_ifs.sv */
`timescale 1ns / 1ps
// Band request channel
interface blmt_in_if;
  logic                          valid;
  logic                          ready;
  logic [blmt_pkg::BAND_W-1:0]   band_index;
  logic [blmt_pkg::MAG_IN_W-1:0] band_magnitude;
  logic                          frame_last;

  modport source (output valid, band_index, band_magnitude, frame_last, input ready);
  modport sink   (input valid, band_index, band_magnitude, frame_last, output ready);
endinterface

// Pixel result channel
interface blmt_out_if;
  logic                         valid;
  logic                         ready;
  logic [blmt_pkg::BAND_W-1:0]  pixel_index;
  logic [blmt_pkg::COLOR_W-1:0] red_level;
  logic [blmt_pkg::COLOR_W-1:0] green_level;
  logic                         pixel_on;
  logic                         frame_done;

  modport source (output valid, pixel_index, red_level, green_level, pixel_on, frame_done,
                  input ready);
  modport sink   (input valid, pixel_index, red_level, green_level, pixel_on, frame_done,
                  output ready);
endinterface

/* design/band_level_meter_tracker.sv */
`timescale 1ns / 1ps
// Band level meter tracker: turns one band magnitude into one pixel colour.
// band_in takes a request (band_index, band_magnitude, frame_last); pixel_out
// returns one result per request (pixel_index, red_level, green_level,
// pixel_on, frame_done). Both use valid/ready; a transfer happens on a clock
// edge with both high. The APB port writes and reads the seven coefficient
// and threshold registers at byte address 4*i; pready is always high.
// A band outside NUM_BANDS goes from S_IDLE straight to S_WB; an in-range
// band is processed by one shared 32x17 multiplier (two or four products per
// blend, up to five blends) and a 16-step restoring divider for the level.
// band_in.ready is high only in S_IDLE, so a new request is taken only after
// the last one has been handed to the output register. A finished result sits
// in an output register, so a new request is accepted while pixel_out stalls;
// the next result waits until that register is taken.
// Reset (rst, synchronous) restores the register defaults, clears noise
// floors, smoothed levels and active flags, and sets every peak to 1.0.
`include "band_level_meter_tracker_defines.svh"
module band_level_meter_tracker #(
  parameter int NUM_BANDS   = 8,
  parameter int FLOOR_BANDS = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  blmt_in_if.sink                       band_in,
  blmt_out_if.source                    pixel_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blmt_pkg::ADDR_W-1:0]   paddr,
  input  logic [blmt_pkg::DATA_W-1:0]   pwdata,
  output logic [blmt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  // Only band indexes reachable through the request field need storage
  localparam int BAND_SPAN = 1 << blmt_pkg::BAND_W;
  localparam int DEPTH     = (NUM_BANDS < BAND_SPAN) ? NUM_BANDS : BAND_SPAN;
  localparam int IDX_W     = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_M0, S_M1, S_M2, S_M3, S_MW, S_MEND, S_DIVSET, S_DIV, S_WB
  } state_t;

  typedef enum logic [2:0] {
    PH_FLOOR, PH_PEAK, PH_SMOOTH, PH_OFFT, PH_COLOR
  } phase_t;

  // Configuration registers
  logic [blmt_pkg::COEF_W-1:0]  floor_rise_coef;
  logic [blmt_pkg::COEF_W-1:0]  floor_fall_coef;
  logic [blmt_pkg::COEF_W-1:0]  peak_attack_coef;
  logic [blmt_pkg::COEF_W-1:0]  peak_decay_coef;
  logic [blmt_pkg::COEF_W-1:0]  smooth_alpha;
  logic [blmt_pkg::LEVEL_W-1:0] on_threshold;
  logic [blmt_pkg::COEF_W-1:0]  off_ratio;

  // Per-band state
  logic [blmt_pkg::MAG_W-1:0]   floor_store  [DEPTH];
  logic [blmt_pkg::MAG_W-1:0]   peak_store   [DEPTH];
  logic [blmt_pkg::LEVEL_W-1:0] smooth_store [DEPTH];
  logic                         active_flags [DEPTH];

  // Sequencer and working registers
  state_t                       state;
  phase_t                       phase;
  logic [blmt_pkg::BAND_W-1:0]  band;
  logic [blmt_pkg::MAG_W-1:0]   mag;
  logic                         last;
  logic                         in_range;
  logic [blmt_pkg::MAG_W-1:0]   cur_floor;
  logic [blmt_pkg::MAG_W-1:0]   cur_peak;
  logic [blmt_pkg::LEVEL_W-1:0] cur_smooth;
  logic                         cur_on;
  logic [blmt_pkg::MAG_W-1:0]   adj;
  logic [blmt_pkg::MAG_W-1:0]   opx;
  logic [blmt_pkg::MAG_W-1:0]   opy;
  logic [blmt_pkg::LEVEL_W-1:0] coef_keep;
  logic [blmt_pkg::LEVEL_W-1:0] coef_new;
  logic                         pair;
  logic                         attack;
  logic [blmt_pkg::MAG_W-1:0]   rem;
  logic [blmt_pkg::QUOT_W-1:0]  quot;
  logic [3:0]                   cnt;
  logic [blmt_pkg::LEVEL_W-1:0] level;
  logic [blmt_pkg::COLOR_W-1:0] red;
  logic [blmt_pkg::COLOR_W-1:0] green;

  // Shared multiplier pipeline
  logic [blmt_pkg::MUL_A_W-1:0] mul_a;
  logic [blmt_pkg::LEVEL_W-1:0] mul_b;
  logic                         mul_go;
  logic                         mul_sh;
  logic                         mul_clr;
  logic [blmt_pkg::PROD_W-1:0]  prod;
  logic                         prod_vld;
  logic                         prod_sh;
  logic                         prod_clr;
  logic [blmt_pkg::ACC_W-1:0]   acc;

  // Output register
  logic                         out_valid;
  logic [blmt_pkg::BAND_W-1:0]  out_index;
  logic [blmt_pkg::COLOR_W-1:0] out_red;
  logic [blmt_pkg::COLOR_W-1:0] out_green;
  logic                         out_on;
  logic                         out_done;

  // Combinational helpers
  logic                         accept;
  logic                         req_in_range;
  logic                         req_floor;
  logic [IDX_W-1:0]             in_idx;
  logic [IDX_W-1:0]             wb_idx;
  logic [blmt_pkg::MAG_W-1:0]   blend_res;
  logic [blmt_pkg::MAG_W:0]     div_shift;
  logic                         div_ge;
  logic [blmt_pkg::MAG_W:0]     div_diff;
  logic [blmt_pkg::QUOT_W-1:0]  quot_next;
  logic                         hys_on;
  logic                         can_load;
  logic [blmt_pkg::LEVEL_W-1:0] fl_coef;
  logic [blmt_pkg::LEVEL_W-1:0] ramp_arg;

  assign accept       = band_in.valid && band_in.ready;
  assign req_in_range = int'(band_in.band_index) < NUM_BANDS;
  assign req_floor    = int'(band_in.band_index) < FLOOR_BANDS;
  assign in_idx       = band_in.band_index[IDX_W-1:0];
  assign wb_idx       = band[IDX_W-1:0];
  assign blend_res    = acc[blmt_pkg::ACC_W-1:blmt_pkg::ACC_W-blmt_pkg::MAG_W];
  assign can_load     = !out_valid || pixel_out.ready;

  // Restoring divide step: shift in one bit, subtract the peak when it fits
  assign div_shift = {rem, 1'b0};
  assign div_ge    = div_shift >= {1'b0, cur_peak};
  assign div_diff  = div_shift - {1'b0, cur_peak};
  assign quot_next = {quot[blmt_pkg::QUOT_W-2:0], div_ge};

  // Hysteresis: turn on at the threshold, off below the scaled threshold
  assign hys_on = cur_on ? !(cur_smooth < blend_res[blmt_pkg::LEVEL_W-1:0])
                         : (cur_smooth >= on_threshold);

  assign fl_coef  = (mag > cur_floor) ? {1'b0, floor_rise_coef} : {1'b0, floor_fall_coef};
  assign ramp_arg = (cur_smooth <= blmt_pkg::HALF_Q16) ? cur_smooth
                                                       : blmt_pkg::ONE_Q16 - cur_smooth;

  assign band_in.ready = (state == S_IDLE);

  assign pixel_out.valid       = out_valid;
  assign pixel_out.pixel_index = out_index;
  assign pixel_out.red_level   = out_red;
  assign pixel_out.green_level = out_green;
  assign pixel_out.pixel_on    = out_on;
  assign pixel_out.frame_done  = out_done;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      floor_rise_coef  <= blmt_pkg::RST_FLOOR_RISE;
      floor_fall_coef  <= blmt_pkg::RST_FLOOR_FALL;
      peak_attack_coef <= blmt_pkg::RST_PEAK_ATTACK;
      peak_decay_coef  <= blmt_pkg::RST_PEAK_DECAY;
      smooth_alpha     <= blmt_pkg::RST_SMOOTH;
      on_threshold     <= blmt_pkg::RST_ON_THRESH;
      off_ratio        <= blmt_pkg::RST_OFF_RATIO;
    end else if (psel && penable && pwrite) begin
      case (paddr[blmt_pkg::ADDR_W-1:2])
        blmt_pkg::REG_FLOOR_RISE:  floor_rise_coef  <= pwdata[blmt_pkg::COEF_W-1:0];
        blmt_pkg::REG_FLOOR_FALL:  floor_fall_coef  <= pwdata[blmt_pkg::COEF_W-1:0];
        blmt_pkg::REG_PEAK_ATTACK: peak_attack_coef <= pwdata[blmt_pkg::COEF_W-1:0];
        blmt_pkg::REG_PEAK_DECAY:  peak_decay_coef  <= pwdata[blmt_pkg::COEF_W-1:0];
        blmt_pkg::REG_SMOOTH:      smooth_alpha     <= pwdata[blmt_pkg::COEF_W-1:0];
        blmt_pkg::REG_ON_THRESH:   on_threshold     <= pwdata[blmt_pkg::LEVEL_W-1:0];
        blmt_pkg::REG_OFF_RATIO:   off_ratio        <= pwdata[blmt_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Configuration read mux
  always_comb begin
    case (paddr[blmt_pkg::ADDR_W-1:2])
      blmt_pkg::REG_FLOOR_RISE:  prdata = {16'd0, floor_rise_coef};
      blmt_pkg::REG_FLOOR_FALL:  prdata = {16'd0, floor_fall_coef};
      blmt_pkg::REG_PEAK_ATTACK: prdata = {16'd0, peak_attack_coef};
      blmt_pkg::REG_PEAK_DECAY:  prdata = {16'd0, peak_decay_coef};
      blmt_pkg::REG_SMOOTH:      prdata = {16'd0, smooth_alpha};
      blmt_pkg::REG_ON_THRESH:   prdata = {15'd0, on_threshold};
      blmt_pkg::REG_OFF_RATIO:   prdata = {16'd0, off_ratio};
      default:                   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Select multiplier operands: low 32 bits then high 16 bits of each 48-bit operand
  always_comb begin
    mul_a   = '0;
    mul_b   = coef_keep;
    mul_go  = 1'b0;
    mul_sh  = 1'b0;
    mul_clr = 1'b0;
    case (state)
      S_M0: begin
        mul_a   = opx[31:0];
        mul_go  = 1'b1;
        mul_clr = 1'b1;
      end
      S_M1: begin
        mul_a  = {16'd0, opx[47:32]};
        mul_go = 1'b1;
        mul_sh = 1'b1;
      end
      S_M2: begin
        mul_a  = opy[31:0];
        mul_b  = coef_new;
        mul_go = 1'b1;
      end
      S_M3: begin
        mul_a  = {16'd0, opy[47:32]};
        mul_b  = coef_new;
        mul_go = 1'b1;
        mul_sh = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer, shared multiplier pipeline, band state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_FLOOR;
      prod_vld  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        floor_store[i]  <= '0;
        peak_store[i]   <= blmt_pkg::MAG_W'(blmt_pkg::ONE_Q16);
        smooth_store[i] <= '0;
        active_flags[i] <= 1'b0;
      end
    end else begin
      // Register the product, then fold it into the accumulator
      prod     <= mul_a * mul_b;
      prod_vld <= mul_go;
      prod_sh  <= mul_sh;
      prod_clr <= mul_clr;
      if (prod_vld) begin
        acc <= (prod_clr ? '0 : acc)
             + (prod_sh ? {prod[31:0], 32'd0} : blmt_pkg::ACC_W'(prod));
      end

      // Drop the result once taken, unless a new one loads now
      if (out_valid && pixel_out.ready && (state != S_WB)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            band       <= band_in.band_index;
            mag        <= {band_in.band_magnitude, 16'd0};
            adj        <= {band_in.band_magnitude, 16'd0};
            last       <= band_in.frame_last;
            in_range   <= req_in_range;
            cur_floor  <= floor_store[in_idx];
            cur_peak   <= peak_store[in_idx];
            cur_smooth <= smooth_store[in_idx];
            cur_on     <= req_in_range && active_flags[in_idx];
            if (!req_in_range) begin
              red    <= '0;
              green  <= '0;
              state  <= S_WB;
            end else begin
              phase <= req_floor ? PH_FLOOR : PH_PEAK;
              state <= S_SETUP;
            end
          end
        end

        // Load blend operands: acc = keep*x + new*y
        S_SETUP: begin
          case (phase)
            PH_FLOOR: begin
              coef_keep <= fl_coef;
              coef_new  <= blmt_pkg::ONE_Q16 - fl_coef;
              opx       <= cur_floor;
              opy       <= mag;
              pair      <= 1'b1;
            end
            PH_PEAK: begin
              attack <= adj > cur_peak;
              opx    <= cur_peak;
              opy    <= adj;
              if (adj > cur_peak) begin
                coef_keep <= {1'b0, peak_attack_coef};
                coef_new  <= blmt_pkg::ONE_Q16 - {1'b0, peak_attack_coef};
                pair      <= 1'b1;
              end else begin
                coef_keep <= {1'b0, peak_decay_coef};
                coef_new  <= '0;
                pair      <= 1'b0;
              end
            end
            PH_SMOOTH: begin
              coef_keep <= blmt_pkg::ONE_Q16 - {1'b0, smooth_alpha};
              coef_new  <= {1'b0, smooth_alpha};
              opx       <= blmt_pkg::MAG_W'(cur_smooth);
              opy       <= blmt_pkg::MAG_W'(level);
              pair      <= 1'b1;
            end
            PH_OFFT: begin
              coef_keep <= {1'b0, off_ratio};
              coef_new  <= '0;
              opx       <= blmt_pkg::MAG_W'(on_threshold);
              opy       <= '0;
              pair      <= 1'b0;
            end
            PH_COLOR: begin
              coef_keep <= blmt_pkg::RAMP_SPAN;
              coef_new  <= '0;
              opx       <= blmt_pkg::MAG_W'(ramp_arg);
              opy       <= '0;
              pair      <= 1'b0;
            end
            default: ;
          endcase
          state <= S_M0;
        end

        S_M0: state <= S_M1;
        S_M1: state <= pair ? S_M2 : S_MW;
        S_M2: state <= S_M3;
        S_M3: state <= S_MW;
        S_MW: state <= S_MEND;

        // Use the blend result of the current phase
        S_MEND: begin
          case (phase)
            PH_FLOOR: begin
              cur_floor <= blend_res;
              adj       <= (mag > blend_res) ? mag - blend_res : '0;
              phase     <= PH_PEAK;
              state     <= S_SETUP;
            end
            PH_PEAK: begin
              if (!attack && blend_res < blmt_pkg::MAG_W'(blmt_pkg::ONE_Q16)) begin
                cur_peak <= blmt_pkg::MAG_W'(blmt_pkg::ONE_Q16);
              end else begin
                cur_peak <= blend_res;
              end
              state <= S_DIVSET;
            end
            PH_SMOOTH: begin
              cur_smooth <= blend_res[blmt_pkg::LEVEL_W-1:0];
              phase      <= PH_OFFT;
              state      <= S_SETUP;
            end
            PH_OFFT: begin
              cur_on <= hys_on;
              red    <= '0;
              green  <= '0;
              if (hys_on && cur_smooth != '0) begin
                phase <= PH_COLOR;
                state <= S_SETUP;
              end else begin
                state <= S_WB;
              end
            end
            PH_COLOR: begin
              red   <= (cur_smooth <= blmt_pkg::HALF_Q16) ? blend_res[blmt_pkg::COLOR_W-1:0]
                                                          : blmt_pkg::RED_MAX;
              green <= blend_res[blmt_pkg::COLOR_W-1:0];
              state <= S_WB;
            end
            default: state <= S_WB;
          endcase
        end

        // Saturate the level at 1.0 or start the divide
        S_DIVSET: begin
          if (adj >= cur_peak) begin
            level <= blmt_pkg::ONE_Q16;
            phase <= PH_SMOOTH;
            state <= S_SETUP;
          end else begin
            rem   <= adj;
            quot  <= '0;
            cnt   <= 4'(blmt_pkg::QUOT_W - 1);
            state <= S_DIV;
          end
        end

        // One quotient bit per cycle
        S_DIV: begin
          rem  <= div_ge ? div_diff[blmt_pkg::MAG_W-1:0] : div_shift[blmt_pkg::MAG_W-1:0];
          quot <= quot_next;
          cnt  <= cnt - 4'd1;
          if (cnt == '0) begin
            level <= {1'b0, quot_next};
            phase <= PH_SMOOTH;
            state <= S_SETUP;
          end
        end

        // Hand over the result and write back the band state
        S_WB: begin
          if (can_load) begin
            out_valid <= 1'b1;
            out_index <= band;
            out_red   <= red;
            out_green <= green;
            out_on    <= cur_on;
            out_done  <= last;
            if (in_range) begin
              floor_store[wb_idx]  <= cur_floor;
              peak_store[wb_idx]   <= cur_peak;
              smooth_store[wb_idx] <= cur_smooth;
              active_flags[wb_idx] <= cur_on;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `BLMT_ASSERT_NOW(a_div_bound, clk, rst, state == S_DIV,
    (rem < cur_peak) && (cur_peak >= blmt_pkg::MAG_W'(blmt_pkg::ONE_Q16)),
    "divider remainder or peak out of range")
  `BLMT_ASSERT_NOW(a_off_dark, clk, rst, pixel_out.valid && !pixel_out.pixel_on,
    (pixel_out.red_level == '0) && (pixel_out.green_level == '0),
    "inactive pixel carries colour")
  `BLMT_ASSERT_NEXT(a_result_loaded, clk, rst, (state == S_WB) && can_load,
    pixel_out.valid && (state == S_IDLE), "finished request not presented")
  `BLMT_ASSERT_NOW(a_idle_quiet, clk, rst, state == S_IDLE, !prod_vld,
    "multiplier busy between requests")

endmodule
